// ===== rtl/sptm_pkg.sv =====
`default_nettype none

package sptm_pkg;

	// Action codes of an input word.
	localparam logic [1:0] ACT_APPEND_A = 2'd0;
	localparam logic [1:0] ACT_APPEND_B = 2'd1;
	localparam logic [1:0] ACT_MERGE    = 2'd2;

	// One stored list entry; row and col together form the row-major position.
	typedef struct packed {
		logic        [7:0]  row;
		logic        [7:0]  col;
		logic signed [15:0] val;
	} entry_t;

	typedef enum logic {
		ST_IDLE,
		ST_MERGE
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/sptm_list.sv =====
`default_nettype none

module sptm_list #(
	parameter int LIST_DEPTH = 16,
	parameter int CW         = 5
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire sptm_pkg::entry_t wr_entry,
	input  wire logic            clr,
	input  wire logic [CW-1:0]   rd_idx,
	output sptm_pkg::entry_t     rd_entry,
	output logic      [CW-1:0]   cnt
);
	import sptm_pkg::*;

	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

	entry_t          store_q [LIST_DEPTH];
	logic   [CW-1:0] cnt_q;
	logic            full;

	assign full = (cnt_q == CW'(LIST_DEPTH));

	// Entries are appended at the fill count; words that arrive when full are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (clr) begin
			cnt_q <= '0;
		end else if (wr_en && !full) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !full && !clr) begin
			store_q[cnt_q[AW-1:0]] <= wr_entry;
		end
	end

	assign rd_entry = store_q[rd_idx[AW-1:0]];
	assign cnt      = cnt_q;

endmodule

`default_nettype wire

// ===== rtl/sparse_triplet_merge_add.sv =====
// Timing: an append is stored at the edge that accepts it. The first result of a merge
// passes the state register and the result register (an empty merge only the result
// register), then one result follows per cycle, one per position. Busy stays high for
// the whole merge walk; appends can be taken every cycle while the block is idle.
// Reset: arst_n clears both fill counts, the sequencer and the result strobe.
// Results are shown for one cycle only; the receiver cannot stall them.
`default_nettype none

module sparse_triplet_merge_add #(
	parameter int LIST_DEPTH = 16,
	parameter int MAX_DIM    = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic        [1:0]  action,
	input  wire logic        [7:0]  row,
	input  wire logic        [7:0]  col,
	input  wire logic signed [15:0] val,
	output logic                    strobe,
	output logic             [7:0]  row_res,
	output logic             [7:0]  col_res,
	output logic signed      [16:0] sum_value,
	output logic                    last,
	output logic                    empty_res,
	output logic             [5:0]  count
);
	import sptm_pkg::*;

	// Width of a fill count or a head index, which must be able to hold LIST_DEPTH itself.
	localparam int CW = $clog2(LIST_DEPTH + 1);

	state_t state_q, state_d;

	logic            accept;
	logic            in_range;
	logic            wr_a, wr_b;
	logic            clr;
	entry_t          wr_entry;
	entry_t          head_a, head_b;
	logic [CW-1:0]   cnt_a, cnt_b;
	logic [CW-1:0]   idx_a_q, idx_b_q;
	logic [CW-1:0]   idx_a_d, idx_b_d;
	logic [5:0]      k_q;

	// Merge step signals.
	logic            a_has, b_has;
	logic            take_a, take_b;
	logic [15:0]     pos_a, pos_b;
	logic signed [16:0] op_a, op_b, sum;
	logic            step_last;

	// Result register.
	logic               strobe_q;
	logic [7:0]         row_q, col_q;
	logic signed [16:0] sum_q;
	logic               last_q, empty_q;
	logic [5:0]         count_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Entries whose row or column fall outside the matrix are dropped.
	assign in_range = ({1'b0, row} < 9'(MAX_DIM)) && ({1'b0, col} < 9'(MAX_DIM));
	assign wr_a     = accept && (action == ACT_APPEND_A) && in_range;
	assign wr_b     = accept && (action == ACT_APPEND_B) && in_range;

	always_comb begin
		wr_entry     = '0;
		wr_entry.row = row;
		wr_entry.col = col;
		wr_entry.val = val;
	end

	sptm_list #(
		.LIST_DEPTH (LIST_DEPTH),
		.CW         (CW)
	) u_list_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_a),
		.wr_entry (wr_entry),
		.clr      (clr),
		.rd_idx   (idx_a_q),
		.rd_entry (head_a),
		.cnt      (cnt_a)
	);

	sptm_list #(
		.LIST_DEPTH (LIST_DEPTH),
		.CW         (CW)
	) u_list_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_b),
		.wr_entry (wr_entry),
		.clr      (clr),
		.rd_idx   (idx_b_q),
		.rd_entry (head_b),
		.cnt      (cnt_b)
	);

	// The shared unit: one position compare and one adder per merge cycle. The head of
	// each list that is consumed feeds the adder; an exhausted list contributes zero, and
	// when both heads sit at the same position both are consumed and summed.
	assign a_has = (idx_a_q < cnt_a);
	assign b_has = (idx_b_q < cnt_b);
	assign pos_a = {head_a.row, head_a.col};
	assign pos_b = {head_b.row, head_b.col};

	always_comb begin
		take_a = 1'b0;
		take_b = 1'b0;
		if (a_has && b_has) begin
			take_a = (pos_a <= pos_b);
			take_b = (pos_b <= pos_a);
		end else begin
			take_a = a_has;
			take_b = b_has;
		end
	end

	assign op_a = take_a ? 17'(head_a.val) : '0;
	assign op_b = take_b ? 17'(head_b.val) : '0;
	assign sum  = op_a + op_b;

	assign idx_a_d   = idx_a_q + (take_a ? CW'(1) : CW'(0));
	assign idx_b_d   = idx_b_q + (take_b ? CW'(1) : CW'(0));
	assign step_last = (idx_a_d == cnt_a) && (idx_b_d == cnt_b);

	// Next state: an empty merge is answered at once from idle; otherwise the sequencer
	// walks the lists and clears them together with the last result.
	always_comb begin
		state_d = state_q;
		clr     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (action == ACT_MERGE)) begin
					if ((cnt_a == '0) && (cnt_b == '0)) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_MERGE;
					end
				end
			end
			ST_MERGE: begin
				if (step_last) begin
					state_d = ST_IDLE;
					clr     = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Head indexes and the emitted word counter restart with every merge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_a_q <= '0;
			idx_b_q <= '0;
			k_q     <= '0;
		end else if (state_q == ST_IDLE) begin
			idx_a_q <= '0;
			idx_b_q <= '0;
			k_q     <= '0;
		end else begin
			idx_a_q <= idx_a_d;
			idx_b_q <= idx_b_d;
			k_q     <= k_q + 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == ST_MERGE) ||
				(accept && (action == ACT_MERGE) && (cnt_a == '0) && (cnt_b == '0));
		end
	end

	// Result payload. The count wraps modulo 64 and is shown only on the last word.
	always_ff @(posedge clk) begin
		if (state_q == ST_MERGE) begin
			row_q   <= take_b ? head_b.row : head_a.row;
			col_q   <= take_b ? head_b.col : head_a.col;
			sum_q   <= sum;
			last_q  <= step_last;
			empty_q <= 1'b0;
			count_q <= step_last ? (k_q + 6'd1) : 6'd0;
		end else if (accept && (action == ACT_MERGE)) begin
			row_q   <= '0;
			col_q   <= '0;
			sum_q   <= '0;
			last_q  <= 1'b1;
			empty_q <= 1'b1;
			count_q <= '0;
		end
	end

	assign strobe    = strobe_q;
	assign row_res   = row_q;
	assign col_res   = col_q;
	assign sum_value = sum_q;
	assign last      = last_q;
	assign empty_res = empty_q;
	assign count     = count_q;

endmodule

`default_nettype wire

// ===== bench/merge_sum_checker.sv =====
`timescale 1ns / 100ps

// Watches the command and result channels of the sparse merge adder, keeps its own copy of
// both entry lists, and compares every result word with the entry that the merge should give.
module merge_sum_checker
	import sptm_pkg::*;
#(
	parameter int LIST_DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic        [1:0]  action,
	input  wire logic        [7:0]  row,
	input  wire logic        [7:0]  col,
	input  wire logic signed [15:0] val,
	input  wire logic               strobe,
	input  wire logic        [7:0]  row_res,
	input  wire logic        [7:0]  col_res,
	input  wire logic signed [16:0] sum_value,
	input  wire logic               last,
	input  wire logic               empty_res,
	input  wire logic        [5:0]  count,
	output int                      mismatches,
	output int                      pending
);

	typedef struct packed {
		logic        [7:0]  row;
		logic        [7:0]  col;
		logic signed [16:0] sum;
		logic               last;
		logic               empty;
		logic        [5:0]  count;
	} sum_entry_t;

	entry_t     list_a [LIST_DEPTH];
	entry_t     list_b [LIST_DEPTH];
	int         fill_a = 0;
	int         fill_b = 0;
	sum_entry_t expected_sums [$];

	// Entries of a merge run are held back by one so that the final one can be marked.
	sum_entry_t held_sum;
	bit         have_held;

	initial begin
		mismatches = 0;
		pending    = 0;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 40)
			$display("[%0t] merge check: %s", $time, what);
	endtask

	task automatic queue_sum(input logic [7:0] r, input logic [7:0] c,
			input logic signed [16:0] s);
		if (have_held)
			expected_sums.push_back(held_sum);
		held_sum  = '{row: r, col: c, sum: s, last: 1'b0, empty: 1'b0, count: 6'd0};
		have_held = 1'b1;
	endtask

	task automatic predict_merge();
		int               i;
		int               j;
		int               emitted;
		logic      [15:0] pos_a;
		logic      [15:0] pos_b;
		logic signed [16:0] s;
		i         = 0;
		j         = 0;
		emitted   = 0;
		have_held = 1'b0;
		if (fill_a == 0 && fill_b == 0) begin
			expected_sums.push_back('{row: 8'd0, col: 8'd0, sum: 17'sd0, last: 1'b1,
				empty: 1'b1, count: 6'd0});
			return;
		end
		// The heads are compared as they stand; an unsorted list is not repaired.
		while (i < fill_a && j < fill_b) begin
			pos_a = {list_a[i].row, list_a[i].col};
			pos_b = {list_b[j].row, list_b[j].col};
			if (pos_a > pos_b) begin
				s = list_b[j].val;
				queue_sum(list_b[j].row, list_b[j].col, s);
				j++;
			end else if (pos_a < pos_b) begin
				s = list_a[i].val;
				queue_sum(list_a[i].row, list_a[i].col, s);
				i++;
			end else begin
				s = list_a[i].val + list_b[j].val;
				queue_sum(list_b[j].row, list_b[j].col, s);
				i++;
				j++;
			end
			emitted++;
		end
		while (i < fill_a) begin
			s = list_a[i].val;
			queue_sum(list_a[i].row, list_a[i].col, s);
			i++;
			emitted++;
		end
		while (j < fill_b) begin
			s = list_b[j].val;
			queue_sum(list_b[j].row, list_b[j].col, s);
			j++;
			emitted++;
		end
		held_sum.last  = 1'b1;
		held_sum.count = 6'(emitted);
		expected_sums.push_back(held_sum);
		fill_a = 0;
		fill_b = 0;
	endtask

	task automatic check_result();
		sum_entry_t want;
		if (expected_sums.size() == 0) begin
			report_mismatch($sformatf("result word row %0d col %0d sum %0d with nothing expected",
				row_res, col_res, sum_value));
			return;
		end
		want = expected_sums.pop_front();
		if (row_res !== want.row || col_res !== want.col || sum_value !== want.sum ||
				last !== want.last || empty_res !== want.empty || count !== want.count)
			report_mismatch($sformatf(
				"got row %0d col %0d sum %0d last %b empty %b count %0d, want %0d %0d %0d %b %b %0d",
				row_res, col_res, sum_value, last, empty_res, count,
				want.row, want.col, want.sum, want.last, want.empty, want.count));
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			fill_a = 0;
			fill_b = 0;
			expected_sums.delete();
			pending <= 0;
		end else begin
			if (start && !busy) begin
				// Indices are 8 bits wide, so with 256 rows and columns none is out of range.
				case (action)
					ACT_APPEND_A: begin
						if (fill_a < LIST_DEPTH) begin
							list_a[fill_a] = '{row: row, col: col, val: val};
							fill_a++;
						end
					end
					ACT_APPEND_B: begin
						if (fill_b < LIST_DEPTH) begin
							list_b[fill_b] = '{row: row, col: col, val: val};
							fill_b++;
						end
					end
					ACT_MERGE: predict_merge();
					default: ;
				endcase
			end
			if (strobe)
				check_result();
			pending <= expected_sums.size();
		end
	end

endmodule

// ===== bench/sparse_triplet_merge_add_test.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the sparse triplet merge adder. The checker beside the block
// predicts and compares every result word; this module only builds the two entry lists,
// issues the merges, and decides the outcome once everything has drained.
module sparse_triplet_merge_add_test;
	import sptm_pkg::*;

	// The action encoding leaves one code unused; the block must ignore it.
	localparam logic [1:0] ACT_NONE = 2'd3;

	localparam int WORD_TARGET = 150;
	// The last stretch of the run goes without any sender gaps.
	localparam int CALM_WORDS  = 30;
	// A correct block never goes this long without taking or giving a word: the longest sender
	// gap is far below this limit and a merge gives one result per cycle.
	localparam int STALL_LIMIT = 2000;

	logic               clk    = 1'b0;
	logic               arst_n = 1'b0;
	logic               start  = 1'b0;
	logic        [1:0]  action = ACT_APPEND_A;
	logic        [7:0]  row    = 8'd0;
	logic        [7:0]  col    = 8'd0;
	logic signed [15:0] val    = 16'sd0;

	logic               busy;
	logic               strobe;
	logic        [7:0]  row_res;
	logic        [7:0]  col_res;
	logic signed [16:0] sum_value;
	logic               last;
	logic               empty_res;
	logic        [5:0]  count;

	int mismatches;
	int pending;
	int words_sent   = 0;
	int quiet_cycles = 0;
	int idle_odds    = 3;
	bit calm         = 1'b0;

	always #4 clk = ~clk;

	sparse_triplet_merge_add dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.action    (action),
		.row       (row),
		.col       (col),
		.val       (val),
		.strobe    (strobe),
		.row_res   (row_res),
		.col_res   (col_res),
		.sum_value (sum_value),
		.last      (last),
		.empty_res (empty_res),
		.count     (count)
	);

	merge_sum_checker #(
		.LIST_DEPTH (16)
	) sum_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.row        (row),
		.col        (col),
		.val        (val),
		.strobe     (strobe),
		.row_res    (row_res),
		.col_res    (col_res),
		.sum_value  (sum_value),
		.last       (last),
		.empty_res  (empty_res),
		.count      (count),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Watchdog: any accepted command word or any result word counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Drives one command word at the falling edge and holds it until a rising edge finds
	// the block not busy. Start stays high on return, so a word that follows at once goes
	// out back to back without start ever dropping.
	task automatic send_word(input logic [1:0] a, input logic [7:0] r, input logic [7:0] c,
			input logic signed [15:0] v);
		@(negedge clk);
		start  <= 1'b1;
		action <= a;
		row    <= r;
		col    <= c;
		val    <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (a != ACT_NONE)
			words_sent++;
		calm = (words_sent >= WORD_TARGET - CALM_WORDS);
	endtask

	// A sender gap whose length is set by n. The payload ports carry junk while start is low, which
	// the block must not pick up.
	task automatic hold_off(input int n);
		@(negedge clk);
		start  <= 1'b0;
		action <= 2'($urandom);
		row    <= 8'($urandom);
		col    <= 8'($urandom);
		val    <= 16'($urandom);
		repeat (n - 1)
			@(negedge clk);
	endtask

	task automatic maybe_idle();
		if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
			hold_off($urandom_range(1, 13));
	endtask

	// Stops sending until the checker has seen every result it expects. Pending is read
	// at the falling edge, well after the checker updated it at the rising edge.
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// One random batch: two lists with row-major positions taken from a common walk, so
	// that many positions land in both lists and get summed. Now and then the walk is long
	// enough to overfill a list, a pair of entries is swapped to break the ordering, or an
	// unused action code is slipped in between the appends.
	task automatic run_batch();
		entry_t side_a [$];
		entry_t side_b [$];
		entry_t spare;
		int     pos;
		int     span;
		int     places;
		int     where;
		int     x;
		int     y;
		bit     from_a;
		case ($urandom_range(0, 3))
			0:       span = 2;
			1:       span = 16;
			2:       span = 300;
			default: span = 4096;
		endcase
		places = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 24) : $urandom_range(0, 10);
		pos    = (places * span < 65536) ? $urandom_range(0, 65535 - places * span) : 0;
		idle_odds = ($urandom_range(0, 1) == 1) ? 3 : 0;
		repeat (places) begin
			if (pos > 65535)
				break;
			spare.row = 8'(pos >> 8);
			spare.col = 8'(pos);
			spare.val = 16'($urandom);
			where = $urandom_range(0, 2);
			if (where != 1)
				side_a.push_back(spare);
			if (where != 0) begin
				spare.val = 16'($urandom);
				side_b.push_back(spare);
			end
			pos += $urandom_range(1, span);
		end
		if ($urandom_range(0, 7) == 0) begin
			if (side_a.size() >= 2) begin
				x = $urandom_range(0, side_a.size() - 1);
				y = $urandom_range(0, side_a.size() - 1);
				spare     = side_a[x];
				side_a[x] = side_a[y];
				side_a[y] = spare;
			end else if (side_b.size() >= 2) begin
				spare     = side_b[0];
				side_b[0] = side_b[side_b.size() - 1];
				side_b[side_b.size() - 1] = spare;
			end
		end
		// Appends to the two lists are interleaved at random; only the order within each
		// list matters to the merge.
		while (side_a.size() + side_b.size() != 0) begin
			from_a = (side_b.size() == 0) || (side_a.size() != 0 && $urandom_range(0, 1) == 1);
			if (from_a) begin
				spare = side_a.pop_front();
				send_word(ACT_APPEND_A, spare.row, spare.col, spare.val);
			end else begin
				spare = side_b.pop_front();
				send_word(ACT_APPEND_B, spare.row, spare.col, spare.val);
			end
			if ($urandom_range(0, 15) == 0)
				send_word(ACT_NONE, 8'($urandom), 8'($urandom), 16'($urandom));
			maybe_idle();
		end
		send_word(ACT_MERGE, 8'($urandom), 8'($urandom), 16'($urandom));
		if ($urandom_range(0, 3) == 0)
			wait_drained();
		else
			maybe_idle();
	endtask

	initial begin
		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// A merge with both lists empty gives the single empty word.
		send_word(ACT_MERGE, 8'hff, 8'hff, 16'sh7fff);
		maybe_idle();
		// The unused action code must leave both lists untouched; the next merge shows it.
		send_word(ACT_NONE, 8'hff, 8'hff, -16'sh8000);

		// Value extremes: matched positions summing to the most negative and most positive
		// totals, an entry at the last position, and a tail left only in list A.
		send_word(ACT_APPEND_A, 8'd0, 8'd0, -16'sh8000);
		send_word(ACT_APPEND_B, 8'd0, 8'd0, -16'sh8000);
		maybe_idle();
		send_word(ACT_APPEND_A, 8'd5, 8'd7, 16'sh7fff);
		send_word(ACT_APPEND_B, 8'd5, 8'd7, 16'sh7fff);
		send_word(ACT_APPEND_B, 8'd128, 8'd3, 16'sd0);
		send_word(ACT_APPEND_A, 8'hff, 8'hff, -16'sd1);
		send_word(ACT_MERGE, 8'd0, 8'd0, 16'sd0);
		wait_drained();

		// Unsorted lists whose matched positions cancel: the zero sums are still emitted,
		// and the merge follows the head comparisons as they fall.
		send_word(ACT_APPEND_A, 8'd9, 8'd9, 16'sd1);
		send_word(ACT_APPEND_A, 8'd1, 8'd1, 16'sd5);
		send_word(ACT_APPEND_A, 8'd2, 8'd2, 16'sd2);
		send_word(ACT_APPEND_B, 8'd9, 8'd9, -16'sd1);
		send_word(ACT_APPEND_B, 8'd1, 8'd1, -16'sd5);
		send_word(ACT_MERGE, 8'h55, 8'haa, 16'sh5555);

		// Overfill list B while A stays empty: the seventeenth append is dropped and the
		// whole run comes from the B tail. Back to back with the previous merge on purpose.
		for (int i = 0; i < 17; i++)
			send_word(ACT_APPEND_B, 8'(i * 15), 8'($urandom), 16'($urandom));
		send_word(ACT_MERGE, 8'($urandom), 8'($urandom), 16'($urandom));
		wait_drained();

		while (words_sent < WORD_TARGET)
			run_batch();

		wait_drained();
		repeat (8)
			@(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
